// ===== rtl/mte_pkg.sv =====
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types, codes and constants of the midi track event encoder.
// ----------------------------------------------------------------------------
package mte_pkg;

    typedef enum logic [2:0] {
        OP_NOTE_ON  = 3'd0,
        OP_NOTE_OFF = 3'd1,
        OP_CTRL_CHG = 3'd2,
        OP_BEND     = 3'd3,
        OP_TEMPO    = 3'd4,
        OP_HEADER   = 3'd5,
        OP_LENGTH   = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    // status nibbles and fixed meta-event bytes
    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_CTRL_CHG = 8'hB0;
    localparam logic [7:0] ST_BEND     = 8'hE0;
    localparam logic [7:0] META_MARK   = 8'hFF;
    localparam logic [7:0] META_TEMPO  = 8'h51;
    localparam logic [7:0] META_LEN    = 8'h03;
    localparam logic [13:0] BEND_OFFSET = 14'h2000;

    // 60000000 us per minute over a Q8.8 tempo
    localparam int              DIV_STEPS = 34;
    localparam logic [33:0]     TEMPO_NUM = 34'd15360000000;
    localparam logic [23:0]     TEMPO_MAX = 24'hFFFFFF;

    localparam logic [4:0] HEADER_LEN = 5'd22;
    localparam logic [4:0] WORD_LEN   = 5'd4;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_start;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tempo;
        logic empty;
        logic last;
        logic div_busy;
    } stat_t;

    // file header: MThd, length 6, format 0, one track, 16 tpq, MTrk, zero length
    function automatic logic [7:0] head_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'h4D;
            5'd1:    b = 8'h54;
            5'd2:    b = 8'h68;
            5'd3:    b = 8'h64;
            5'd7:    b = 8'h06;
            5'd11:   b = 8'h01;
            5'd13:   b = 8'h10;
            5'd14:   b = 8'h4D;
            5'd15:   b = 8'h54;
            5'd16:   b = 8'h72;
            5'd17:   b = 8'h6B;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/mte_if.sv =====
// ----------------------------------------------------------------------------
// mte_if
// Channel interfaces: event requests in, track bytes out.
// ----------------------------------------------------------------------------
interface mte_event_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic [27:0]        delta_ticks;
    logic [3:0]         channel;
    logic [6:0]         key_or_controller;
    logic [6:0]         velocity_or_value;
    logic signed [13:0] bend_amount;
    logic [15:0]        tempo_bpm;

    modport source (
        output valid, operation, delta_ticks, channel, key_or_controller,
               velocity_or_value, bend_amount, tempo_bpm,
        input  ready
    );
    modport sink (
        input  valid, operation, delta_ticks, channel, key_or_controller,
               velocity_or_value, bend_amount, tempo_bpm,
        output ready
    );
endinterface

interface mte_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_byte;

    modport source (output valid, out_byte, last_byte, input ready);
    modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

// ===== rtl/mte_div.sv =====
// ----------------------------------------------------------------------------
// mte_div
// Restoring divider, one quotient bit per cycle: tempo constant over bpm,
// saturated to 24 bits.
// ----------------------------------------------------------------------------
module mte_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic [23:0] quotient
);

    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [33:0] num_reg, num_next;
    logic [23:0] quot_reg, quot_next;
    logic        ovf_reg, ovf_next;
    logic [16:0] rem_sh;
    logic [16:0] rem_sub;
    logic        ge;

    assign rem_sh  = {rem_reg, num_reg[33]};
    assign ge      = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            num_next  = mte_pkg::TEMPO_NUM;
            quot_next = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? rem_sub[15:0] : rem_sh[15:0];
            num_next  = {num_reg[32:0], 1'b0};
            quot_next = {quot_reg[22:0], ge};
            // any quotient bit above bit 23 forces saturation
            ovf_next  = ovf_reg | quot_reg[23];
            cnt_next  = cnt_reg + 6'd1;
            if (cnt_reg == 6'(mte_pkg::DIV_STEPS - 1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign busy     = busy_reg;
    assign quotient = ovf_reg ? mte_pkg::TEMPO_MAX : quot_reg;

endmodule

// ===== rtl/mte_dp.sv =====
// ----------------------------------------------------------------------------
// mte_dp
// Datapath: request capture, byte sequencing, running byte count, tempo
// divider and the output byte register.
// ----------------------------------------------------------------------------
module mte_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  mte_pkg::cmd_t       cmd,
    output mte_pkg::stat_t      stat,
    mte_event_if.sink           request,
    output logic [7:0]          out_byte,
    output logic                last_byte
);

    mte_pkg::op_t op_reg;
    logic [27:0]  delta_reg;
    logic [3:0]   chan_reg;
    logic [6:0]   kc_reg;
    logic [6:0]   vv_reg;
    logic [13:0]  bend_reg;
    logic [15:0]  tempo_reg;
    logic [2:0]   groups_reg;
    logic [4:0]   len_reg;
    logic [4:0]   idx_reg;
    logic [31:0]  count_reg;
    logic [7:0]   out_byte_reg;
    logic         last_byte_reg;

    mte_pkg::op_t op_in;
    logic [2:0]   groups_in;
    logic [4:0]   len_in;
    logic [7:0]   byte_sel;
    logic [7:0]   msg_byte;
    logic [7:0]   vlq_byte;
    logic [1:0]   vlq_shift;
    logic [2:0]   msg_idx;
    logic [13:0]  bend_off;
    logic [23:0]  us;
    logic         div_busy;
    logic         is_last;

    mte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .divisor  (tempo_reg),
        .busy     (div_busy),
        .quotient (us)
    );

    assign op_in = mte_pkg::op_t'(request.operation);

    // number of seven-bit groups in the delta time
    always_comb
    begin
        priority if (request.delta_ticks[27:21] != '0)
            groups_in = 3'd4;
        else if (request.delta_ticks[20:14] != '0)
            groups_in = 3'd3;
        else if (request.delta_ticks[13:7] != '0)
            groups_in = 3'd2;
        else
            groups_in = 3'd1;
    end

    always_comb
    begin
        unique case (op_in)
            mte_pkg::OP_NOTE_ON,
            mte_pkg::OP_NOTE_OFF,
            mte_pkg::OP_CTRL_CHG,
            mte_pkg::OP_BEND:    len_in = 5'(groups_in) + 5'd3;
            mte_pkg::OP_TEMPO:   len_in = 5'(groups_in) + 5'd6;
            mte_pkg::OP_HEADER:  len_in = mte_pkg::HEADER_LEN;
            mte_pkg::OP_LENGTH:  len_in = mte_pkg::WORD_LEN;
            default:             len_in = 5'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= op_in;
            delta_reg  <= request.delta_ticks;
            chan_reg   <= request.channel;
            kc_reg     <= request.key_or_controller;
            vv_reg     <= request.velocity_or_value;
            bend_reg   <= request.bend_amount;
            tempo_reg  <= request.tempo_bpm;
            groups_reg <= groups_in;
        end
        if (cmd.load_out)
        begin
            out_byte_reg  <= byte_sel;
            last_byte_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                len_reg <= len_in;
                idx_reg <= '0;
                if (op_in <= mte_pkg::OP_TEMPO)
                    count_reg <= count_reg + 32'(len_in);
            end
            else if (cmd.load_out)
                idx_reg <= idx_reg + 5'd1;
        end
    end

    // delta time byte, most significant group first
    assign vlq_shift = 2'(groups_reg - 3'd1 - idx_reg[2:0]);
    always_comb
    begin
        unique case (vlq_shift)
            2'd0: vlq_byte = {1'b0, delta_reg[6:0]};
            2'd1: vlq_byte = {1'b1, delta_reg[13:7]};
            2'd2: vlq_byte = {1'b1, delta_reg[20:14]};
            2'd3: vlq_byte = {1'b1, delta_reg[27:21]};
        endcase
    end

    assign bend_off = bend_reg ^ mte_pkg::BEND_OFFSET;
    assign msg_idx  = 3'(idx_reg - 5'(groups_reg));

    always_comb
    begin
        msg_byte = 8'h00;
        unique case (op_reg)
            mte_pkg::OP_NOTE_ON,
            mte_pkg::OP_NOTE_OFF,
            mte_pkg::OP_CTRL_CHG:
            begin
                case (msg_idx)
                    3'd0:
                    begin
                        if (op_reg == mte_pkg::OP_NOTE_ON)
                            msg_byte = mte_pkg::ST_NOTE_ON | {4'h0, chan_reg};
                        else if (op_reg == mte_pkg::OP_NOTE_OFF)
                            msg_byte = mte_pkg::ST_NOTE_OFF | {4'h0, chan_reg};
                        else
                            msg_byte = mte_pkg::ST_CTRL_CHG | {4'h0, chan_reg};
                    end
                    3'd1:    msg_byte = {1'b0, kc_reg};
                    // note off always carries zero velocity
                    default: msg_byte = (op_reg == mte_pkg::OP_NOTE_OFF) ?
                                        8'h00 : {1'b0, vv_reg};
                endcase
            end
            mte_pkg::OP_BEND:
            begin
                case (msg_idx)
                    3'd0:    msg_byte = mte_pkg::ST_BEND | {4'h0, chan_reg};
                    3'd1:    msg_byte = {1'b0, bend_off[6:0]};
                    default: msg_byte = {1'b0, bend_off[13:7]};
                endcase
            end
            mte_pkg::OP_TEMPO:
            begin
                case (msg_idx)
                    3'd0:    msg_byte = mte_pkg::META_MARK;
                    3'd1:    msg_byte = mte_pkg::META_TEMPO;
                    3'd2:    msg_byte = mte_pkg::META_LEN;
                    3'd3:    msg_byte = us[23:16];
                    3'd4:    msg_byte = us[15:8];
                    default: msg_byte = us[7:0];
                endcase
            end
            default:         msg_byte = 8'h00;
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            mte_pkg::OP_HEADER:
                byte_sel = mte_pkg::head_byte(idx_reg);
            mte_pkg::OP_LENGTH:
            begin
                unique case (idx_reg[1:0])
                    2'd0: byte_sel = count_reg[31:24];
                    2'd1: byte_sel = count_reg[23:16];
                    2'd2: byte_sel = count_reg[15:8];
                    2'd3: byte_sel = count_reg[7:0];
                endcase
            end
            default:
                byte_sel = (idx_reg < 5'(groups_reg)) ? vlq_byte : msg_byte;
        endcase
    end

    assign is_last = (idx_reg == len_reg - 5'd1);

    assign stat.is_tempo = (op_reg == mte_pkg::OP_TEMPO);
    assign stat.empty    = (len_reg == 5'd0);
    assign stat.last     = is_last;
    assign stat.div_busy = div_busy;

    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

// ===== rtl/mte_ctrl.sv =====
// ----------------------------------------------------------------------------
// mte_ctrl
// Controller: request handshake, divider wait and output byte handshake.
// ----------------------------------------------------------------------------
module mte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    input  mte_pkg::stat_t stat,
    output mte_pkg::cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIVIDE,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (stat.empty)
                    state_next = S_IDLE;
                else if (stat.is_tempo)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVIDE;
                end
                else
                    state_next = S_EMIT;
            end
            S_DIVIDE:
            begin
                if (!stat.div_busy)
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    if (stat.last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/midi_track_event_encoder.sv =====
// ----------------------------------------------------------------------------
// midi_track_event_encoder
// Encodes MIDI event requests into Standard MIDI File track bytes.
// ----------------------------------------------------------------------------
// request channel: one event per transfer (note on/off, control change,
//   pitch bend, tempo, file header, track length); operation code 7 is
//   taken and produces nothing
// stream channel: one track byte per transfer, last_byte marks the final
//   byte of a request
// every channel or tempo event starts with its delta time as a 1 to 4 byte
//   variable-length quantity; a running 32-bit track byte count grows with
//   each such event and is reported by the track length request
// first byte: after the request transfer the controller passes S_CHECK and
//   then loads it in S_EMIT; a tempo request waits in S_DIVIDE for the
//   34-step bit-serial divider before S_EMIT
// unless the receiver stalls, the byte sequencer loads one byte per cycle
//   into a single output register and a new request is taken as soon as
//   the last byte is loaded
// receiver stall: the output register holds its byte and the sequencer waits
// reset: byte count cleared, controller idle, no byte pending
// ----------------------------------------------------------------------------
module midi_track_event_encoder (
    input  logic        clk,
    input  logic        rst_n,
    mte_event_if.sink   request,
    mte_byte_if.source  stream
);

    mte_pkg::cmd_t  cmd;
    mte_pkg::stat_t stat;

    // control: handshakes and sequencing
    mte_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .in_ready  (request.ready),
        .out_valid (stream.valid),
        .out_ready (stream.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // data: capture, byte selection, count and divider
    mte_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .request   (request),
        .out_byte  (stream.out_byte),
        .last_byte (stream.last_byte)
    );

endmodule
